// ----- hdl/gpg_pkg.sv -----
`timescale 1ns / 1ps

package gpg_pkg;

    // Output lanes of the block; legs past this count are never computed.
    localparam int OUT_LEGS  = 4;
    localparam int LEG_IDX_W = 2;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_RATE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_STARTS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_DURATIONS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STANCE_MODE      = 3'd6;

    localparam logic [15:0] NOMINAL_RATE_RST  = 16'd256;
    localparam logic [15:0] STEP_TIME_RST     = 16'd655;
    localparam logic [15:0] STRIDE_PERIOD_RST = 16'd256;

    // Fixed-point landmarks of a Q0.16 phase.
    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam logic [15:0] HALF_Q16    = 16'h8000;
    localparam logic [15:0] QUARTER_Q16 = 16'h4000;
    localparam int          IDX_ROUND   = 8192;

    // pi/2 in Q2.30, used to place the table angles.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Taylor series denominators (2n)(2n+1) for n = 1 to 10.
    localparam logic [63:0] TAYLOR_DIV [1:10] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    typedef struct packed {
        logic                 capture;
        logic                 mul_rate;
        logic                 phase_upd;
        logic                 leg_load;
        logic                 mul_time;
        logic                 mul_lift;
        logic                 wr_lift;
        logic                 out_load;
        logic [LEG_IDX_W-1:0] leg;
    } cmd_t;

    typedef struct packed {
        logic stance;
    } sts_t;

    // Sine of a Q2.30 angle, rounded to Q1.16; only evaluated at elaboration.
    function automatic logic [16:0] sine_from_angle(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 10; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = '0;
        r = ($unsigned(sum) + 64'd8192) >> 14;
        if (r > 64'd65536)
            r = 64'd65536;
        return r[16:0];
    endfunction

endpackage

// ----- hdl/gpg_ctrl.sv -----
`timescale 1ns / 1ps

module gpg_ctrl #(
    parameter int LEG_COUNT = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  gpg_pkg::sts_t sts,
    output gpg_pkg::cmd_t cmd
);

    localparam int LEGS_USED = (LEG_COUNT < gpg_pkg::OUT_LEGS) ? LEG_COUNT : gpg_pkg::OUT_LEGS;
    localparam logic [gpg_pkg::LEG_IDX_W-1:0] LAST_LEG = gpg_pkg::LEG_IDX_W'(LEGS_USED - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RATE  = 3'd1;
    localparam logic [2:0] S_PHASE = 3'd2;
    localparam logic [2:0] S_SEL   = 3'd3;
    localparam logic [2:0] S_TMUL  = 3'd4;
    localparam logic [2:0] S_LMUL  = 3'd5;
    localparam logic [2:0] S_LWR   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]                      state_reg, state_next;
    logic [gpg_pkg::LEG_IDX_W-1:0]   leg_reg, leg_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        leg_next       = leg_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.leg        = leg_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.stance ? S_FIN : S_RATE;
                end
            end
            S_RATE:
            begin
                cmd.mul_rate = 1'b1;
                state_next   = S_PHASE;
            end
            S_PHASE:
            begin
                cmd.phase_upd = 1'b1;
                leg_next      = '0;
                state_next    = S_SEL;
            end
            S_SEL:
            begin
                cmd.leg_load = 1'b1;
                state_next   = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.mul_time = 1'b1;
                state_next   = S_LMUL;
            end
            S_LMUL:
            begin
                cmd.mul_lift = 1'b1;
                state_next   = S_LWR;
            end
            S_LWR:
            begin
                cmd.wr_lift = 1'b1;
                if (leg_reg == LAST_LEG)
                    state_next = S_FIN;
                else
                begin
                    leg_next   = leg_reg + 1'b1;
                    state_next = S_SEL;
                end
            end
            S_FIN:
            begin
                // The result register may still hold an untaken beat.
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            leg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            leg_reg       <= leg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("controller stayed idle after accepting a beat");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while a beat was waiting");

    a_leg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEL |-> leg_reg <= LAST_LEG)
        else $error("leg counter beyond the configured leg count");

    a_one_multiply: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul_rate, cmd.mul_time, cmd.mul_lift}))
        else $error("shared multiplier requested twice in one cycle");

endmodule

// ----- hdl/gpg_dp.sv -----
`timescale 1ns / 1ps

module gpg_dp #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [gpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic signed [15:0]               freq_adjust,
    input  gpg_pkg::cmd_t                    cmd,
    output gpg_pkg::sts_t                    sts,
    output logic [15:0]                      phase_out,
    output logic [3:0]                       contact_mask,
    output logic [15:0]                      time_left_0,
    output logic [15:0]                      time_left_1,
    output logic [15:0]                      time_left_2,
    output logic [15:0]                      time_left_3,
    output logic [15:0]                      lift_0,
    output logic [15:0]                      lift_1,
    output logic [15:0]                      lift_2,
    output logic [15:0]                      lift_3
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SC_W  = IDX_W + 15;
    localparam int NL    = gpg_pkg::OUT_LEGS;

    // Configuration registers.
    logic [15:0] nominal_rate_reg;
    logic [15:0] step_time_reg;
    logic [15:0] stride_period_reg;
    logic [15:0] clearance_reg;
    logic [63:0] swing_starts_reg;
    logic [63:0] swing_durations_reg;
    logic        stance_mode_reg;

    // Working registers.
    logic [15:0]        freq_reg;
    logic signed [35:0] prod_reg;
    logic [15:0]        shifted_reg;
    logic [16:0]        span_reg;
    logic               stance_reg;
    logic               lift_on_reg;
    logic [16:0]        sine_reg;

    // Gait state.
    logic [15:0] phase_reg;
    logic [3:0]  contacts_reg;
    logic [15:0] time_left_reg [NL];
    logic [15:0] lift_reg [NL];

    // Result register.
    logic [15:0] out_phase_reg;
    logic [3:0]  out_contacts_reg;
    logic [15:0] out_time_left_reg [NL];
    logic [15:0] out_lift_reg [NL];

    logic [16:0] sine_tab [0:SINE_TABLE_DEPTH];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_sine
        localparam logic [63:0] ANG =
            (gpg_pkg::HALF_PI_Q30 * 64'(g)) / 64'(SINE_TABLE_DEPTH);
        localparam logic [16:0] ENT = gpg_pkg::sine_from_angle(ANG);
        assign sine_tab[g] = ENT;
    end

    assign sts.stance = stance_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_rate_reg    <= gpg_pkg::NOMINAL_RATE_RST;
            step_time_reg       <= gpg_pkg::STEP_TIME_RST;
            stride_period_reg   <= gpg_pkg::STRIDE_PERIOD_RST;
            clearance_reg       <= '0;
            swing_starts_reg    <= '0;
            swing_durations_reg <= '0;
            stance_mode_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gpg_pkg::REG_NOMINAL_RATE:     nominal_rate_reg    <= cfg_wdata[15:0];
                gpg_pkg::REG_STEP_TIME:        step_time_reg       <= cfg_wdata[15:0];
                gpg_pkg::REG_STRIDE_PERIOD:    stride_period_reg   <= cfg_wdata[15:0];
                gpg_pkg::REG_CLEARANCE_HEIGHT: clearance_reg       <= cfg_wdata[15:0];
                gpg_pkg::REG_SWING_STARTS:     swing_starts_reg    <= cfg_wdata;
                gpg_pkg::REG_SWING_DURATIONS:  swing_durations_reg <= cfg_wdata;
                gpg_pkg::REG_STANCE_MODE:      stance_mode_reg     <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Rate in Q8.8, 18 bits signed so that nominal plus adjustment cannot overflow.
    logic signed [17:0] rate_w;
    assign rate_w = {2'b00, nominal_rate_reg} + {{2{freq_reg[15]}}, freq_reg};

    // Shared multiplier.
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] mul_p;

    always_comb
    begin
        if (cmd.mul_rate)
        begin
            mul_a = rate_w;
            mul_b = {2'b00, step_time_reg};
        end
        else if (cmd.mul_time)
        begin
            mul_a = {1'b0, span_reg};
            mul_b = {2'b00, stride_period_reg};
        end
        else
        begin
            mul_a = {2'b00, clearance_reg};
            mul_b = lift_on_reg ? {1'b0, sine_reg} : '0;
        end
    end

    assign mul_p = mul_a * mul_b;

    // Per-leg phase geometry for the leg the controller points at.
    logic [15:0] st_w;
    logic [15:0] du_w;
    logic [15:0] send_w;
    logic [15:0] shifted_w;
    logic [16:0] limit_w;
    logic        stance_w;
    logic [16:0] span_w;
    logic        lift_on_w;

    assign st_w      = swing_starts_reg[{cmd.leg, 4'b0000} +: 16];
    assign du_w      = swing_durations_reg[{cmd.leg, 4'b0000} +: 16];
    assign send_w    = st_w + du_w;
    assign shifted_w = phase_reg - send_w;
    // A zero duration gives a limit of one whole cycle.
    assign limit_w   = gpg_pkg::ONE_Q16 - {1'b0, du_w};
    assign stance_w  = {1'b0, shifted_w} < limit_w;
    assign span_w    = stance_w ? (limit_w - {1'b0, shifted_w})
                                : (gpg_pkg::ONE_Q16 - {1'b0, shifted_w});
    assign lift_on_w = !stance_w && (shifted_w > gpg_pkg::HALF_Q16);

    // Fold the second half cycle onto the quarter-wave table.
    logic [15:0]      y_w;
    logic [15:0]      q_w;
    logic [SC_W-1:0]  scaled_w;
    logic [IDX_W:0]   idx_raw_w;
    logic [IDX_W-1:0] idx_w;

    assign y_w       = shifted_reg - gpg_pkg::HALF_Q16;
    assign q_w       = (y_w <= gpg_pkg::QUARTER_Q16) ? y_w : (gpg_pkg::HALF_Q16 - y_w);
    assign scaled_w  = SC_W'(q_w[14:0]) * SC_W'(SINE_TABLE_DEPTH) + SC_W'(gpg_pkg::IDX_ROUND);
    assign idx_raw_w = scaled_w[SC_W-1:14];
    assign idx_w     = (idx_raw_w > (IDX_W + 1)'(SINE_TABLE_DEPTH))
                       ? IDX_W'(SINE_TABLE_DEPTH) : idx_raw_w[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            freq_reg <= freq_adjust;
        if (cmd.mul_rate || cmd.mul_time || cmd.mul_lift)
            prod_reg <= mul_p;
        if (cmd.leg_load)
        begin
            shifted_reg <= shifted_w;
            span_reg    <= span_w;
            stance_reg  <= stance_w;
            lift_on_reg <= lift_on_w;
        end
        if (cmd.mul_time)
            sine_reg <= sine_tab[idx_w];
        if (cmd.out_load)
        begin
            out_phase_reg    <= phase_reg;
            out_contacts_reg <= contacts_reg;
            for (int i = 0; i < NL; i++)
            begin
                out_time_left_reg[i] <= time_left_reg[i];
                out_lift_reg[i]      <= lift_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            contacts_reg <= '0;
            for (int i = 0; i < NL; i++)
            begin
                time_left_reg[i] <= '0;
                lift_reg[i]      <= '0;
            end
        end
        else
        begin
            // The increment is the product floored to Q0.16, wrapping modulo one.
            if (cmd.phase_upd)
                phase_reg <= phase_reg + prod_reg[23:8];
            if (cmd.mul_lift)
            begin
                time_left_reg[cmd.leg] <= prod_reg[31:16];
                contacts_reg[cmd.leg]  <= stance_reg;
            end
            if (cmd.wr_lift)
                lift_reg[cmd.leg] <= prod_reg[31:16];
        end
    end

    assign phase_out    = out_phase_reg;
    assign contact_mask = out_contacts_reg;
    assign time_left_0  = out_time_left_reg[0];
    assign time_left_1  = out_time_left_reg[1];
    assign time_left_2  = out_time_left_reg[2];
    assign time_left_3  = out_time_left_reg[3];
    assign lift_0       = out_lift_reg[0];
    assign lift_1       = out_lift_reg[1];
    assign lift_2       = out_lift_reg[2];
    assign lift_3       = out_lift_reg[3];

    a_stance_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture && stance_mode_reg |=> $stable(phase_reg))
        else $error("phase moved on a step taken in stance mode");

    a_no_lift_in_stance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.leg_load |=> !(stance_reg && lift_on_reg))
        else $error("stance leg flagged for lift");

    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.leg_load |=> span_reg <= gpg_pkg::ONE_Q16)
        else $error("time-left span exceeds one cycle");

endmodule

// ----- hdl/gait_phase_generator.sv -----
`timescale 1ns / 1ps
// Walking, an accepted item passes through RATE and PHASE, then SEL, TMUL, LMUL and LWR
// for each of N = min(LEG_COUNT, 4) legs, then FIN; in stance mode it goes straight to FIN.
// One shared 18x18 multiplier serves the rate and each leg twice. The next item is taken
// only once the last one is in the output register, while that result may still wait there;
// only a result still untaken when the next one is ready stalls the sequence.
// Reset (rst_n, asynchronous, active low) restores the register defaults, clears phase, gait
// state and out_valid but not the held output values; no clearing pass is needed.

module gait_phase_generator #(
    parameter int LEG_COUNT        = 4,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [gpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [15:0]               freq_adjust,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [15:0]                      phase_out,
    output logic [3:0]                       contact_mask,
    output logic [15:0]                      time_left_0,
    output logic [15:0]                      time_left_1,
    output logic [15:0]                      time_left_2,
    output logic [15:0]                      time_left_3,
    output logic [15:0]                      lift_0,
    output logic [15:0]                      lift_1,
    output logic [15:0]                      lift_2,
    output logic [15:0]                      lift_3
);

    gpg_pkg::cmd_t cmd;
    gpg_pkg::sts_t sts;

    gpg_ctrl #(
        .LEG_COUNT (LEG_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gpg_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .freq_adjust  (freq_adjust),
        .cmd          (cmd),
        .sts          (sts),
        .phase_out    (phase_out),
        .contact_mask (contact_mask),
        .time_left_0  (time_left_0),
        .time_left_1  (time_left_1),
        .time_left_2  (time_left_2),
        .time_left_3  (time_left_3),
        .lift_0       (lift_0),
        .lift_1       (lift_1),
        .lift_2       (lift_2),
        .lift_3       (lift_3)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import gpg_pkg::*;

    localparam int SINE_DEPTH      = 256;
    localparam int DRAIN_CYCLES    = 4 * OUT_LEGS + 8;
    localparam int RANDOM_PHASES   = 14;
    localparam int BEATS_PER_PHASE = 125;
    localparam int PRINT_LIMIT     = 100;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [15:0]      phase;
        logic [3:0]       mask;
        logic [3:0][15:0] time_left;
        logic [3:0][15:0] lift;
    } gait_result_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_BEAT,
        ROW_KNOWN
    } row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [15:0]           adj;
        gait_result_t          known;
    } plan_row_t;

    localparam gait_result_t AT_REST         = '0;
    localparam gait_result_t STEP_FROM_RESET = '{16'd655, 4'hF, {4{16'd253}}, '0};

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic signed [15:0]    freq_adjust = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [15:0]           phase_out;
    logic [3:0]            contact_mask;
    logic [15:0]           time_left_0, time_left_1, time_left_2, time_left_3;
    logic [15:0]           lift_0, lift_1, lift_2, lift_3;

    // Register copy and gait state of the predictor.
    logic [15:0]      rate_nom         = NOMINAL_RATE_RST;
    logic [15:0]      step_dt          = STEP_TIME_RST;
    logic [15:0]      stride_len       = STRIDE_PERIOD_RST;
    logic [15:0]      lift_peak        = '0;
    logic [63:0]      swing_start_word = '0;
    logic [63:0]      swing_len_word   = '0;
    logic             frozen           = 1'b0;
    logic [15:0]      phase_acc        = '0;
    logic [3:0]       held_mask        = '0;
    logic [3:0][15:0] held_time        = '0;
    logic [3:0][15:0] held_clear       = '0;

    int unsigned  quarter_sine [0:SINE_DEPTH];
    gait_result_t pending_steps [$];
    bit           steady_flow   = 1'b0;
    bit           busy          = 1'b0;
    int           mismatches    = 0;
    int           results_seen  = 0;
    int           beats_sent    = 0;
    int           frozen_beats  = 0;
    int           writes_done   = 0;

    plan_row_t opening_plan [36] = '{
        '{ROW_WRITE, REG_STANCE_MODE,      64'd1,                 16'h0000, '0},
        '{ROW_KNOWN, '0,                   '0,                    16'h7FFF, AT_REST},
        '{ROW_WRITE, REG_STANCE_MODE,      64'd0,                 16'h0000, '0},
        '{ROW_KNOWN, '0,                   '0,                    16'h0000, STEP_FROM_RESET},
        '{ROW_KNOWN, '0,                   '0,                    16'hFF00, STEP_FROM_RESET},
        '{ROW_WRITE, REG_NOMINAL_RATE,     64'd0,                 16'h0000, '0},
        '{ROW_WRITE, REG_STEP_TIME,        64'd256,               16'h0000, '0},
        '{ROW_WRITE, REG_CLEARANCE_HEIGHT, 64'hFFFF,              16'h0000, '0},
        '{ROW_WRITE, REG_SWING_STARTS,     64'hC000_8000_4000_0000, 16'h0000, '0},
        '{ROW_WRITE, REG_SWING_DURATIONS,  64'hFFFF_8000_4000_0000, 16'h0000, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'hFD71, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h4000, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h4000, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h0001, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h3FFF, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h4000, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h8000, '0},
        '{ROW_WRITE, REG_STRIDE_PERIOD,    64'hFFFF,              16'h0000, '0},
        '{ROW_WRITE, REG_NOMINAL_RATE,     64'hFFFF,              16'h0000, '0},
        '{ROW_WRITE, REG_STEP_TIME,        64'hFFFF,              16'h0000, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h7FFF, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h8000, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h0001, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'hFFFF, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h5555, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'hAAAA, '0},
        '{ROW_WRITE, REG_STEP_TIME,        64'd0,                 16'h0000, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h1234, '0},
        '{ROW_WRITE, REG_STANCE_MODE,      64'd1,                 16'h0000, '0},
        '{ROW_WRITE, REG_NOMINAL_RATE,     64'h0100,              16'h0000, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h7FFF, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h0000, '0},
        '{ROW_WRITE, REG_SPARE,            '1,                    16'h0000, '0},
        '{ROW_WRITE, REG_STANCE_MODE,      64'd0,                 16'h0000, '0},
        '{ROW_WRITE, REG_STRIDE_PERIOD,    64'd0,                 16'h0000, '0},
        '{ROW_BEAT,  '0,                   '0,                    16'h0000, '0}
    };

    gait_phase_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .freq_adjust  (freq_adjust),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .phase_out    (phase_out),
        .contact_mask (contact_mask),
        .time_left_0  (time_left_0),
        .time_left_1  (time_left_1),
        .time_left_2  (time_left_2),
        .time_left_3  (time_left_3),
        .lift_0       (lift_0),
        .lift_1       (lift_1),
        .lift_2       (lift_2),
        .lift_3       (lift_3)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sine of a quarter-turn fraction by an integer Taylor series in Q2.30.
    function automatic int unsigned sine_point(input int k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned rounded;
        longint          acc;
        ang    = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int n = 1; n <= 10; n++)
        begin
            term = ((term * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        rounded = (longint'(acc) + 8192) >> 14;
        if (rounded > 65536)
            rounded = 65536;
        return int'(rounded);
    endfunction

    function automatic logic [15:0] swing_lift(input logic [15:0] shifted);
        logic [15:0] y;
        logic [15:0] q;
        int          idx;
        logic [31:0] scaled;
        if (shifted <= HALF_Q16)
            return '0;
        y   = shifted - HALF_Q16;
        q   = (y <= QUARTER_Q16) ? y : HALF_Q16 - y;
        idx = (int'(q) * SINE_DEPTH + IDX_ROUND) / 16384;
        if (idx > SINE_DEPTH)
            idx = SINE_DEPTH;
        scaled = lift_peak * quarter_sine[idx];
        return scaled[31:16];
    endfunction

    // One control step: unless frozen, advance the phase and place every leg in its cycle.
    function automatic gait_result_t advance_gait(input logic signed [15:0] adj);
        longint       prod;
        logic [15:0]  start_ph;
        logic [15:0]  span_ph;
        logic [15:0]  shifted;
        logic [16:0]  limit;
        logic [16:0]  remain;
        logic [32:0]  scaled;
        gait_result_t res;
        if (!frozen)
        begin
            prod      = (longint'(rate_nom) + longint'(adj)) * longint'(step_dt);
            prod      = prod >>> 8;
            phase_acc = phase_acc + prod[15:0];
            held_mask = '0;
            for (int leg = 0; leg < OUT_LEGS; leg++)
            begin
                start_ph = swing_start_word[16 * leg +: 16];
                span_ph  = swing_len_word[16 * leg +: 16];
                shifted  = phase_acc - (start_ph + span_ph);
                limit    = ONE_Q16 - {1'b0, span_ph};
                if ({1'b0, shifted} < limit)
                begin
                    held_mask[leg]  = 1'b1;
                    remain          = limit - {1'b0, shifted};
                    held_clear[leg] = '0;
                end
                else
                begin
                    remain          = ONE_Q16 - {1'b0, shifted};
                    held_clear[leg] = swing_lift(shifted);
                end
                scaled         = remain * stride_len;
                held_time[leg] = scaled[31:16];
            end
        end
        res.phase     = phase_acc;
        res.mask      = held_mask;
        res.time_left = held_time;
        res.lift      = held_clear;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("Mismatch at result %0d, %s: got %h, expected %h",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_NOMINAL_RATE:     rate_nom = data[15:0];
            REG_STEP_TIME:        step_dt = data[15:0];
            REG_STRIDE_PERIOD:    stride_len = data[15:0];
            REG_CLEARANCE_HEIGHT: lift_peak = data[15:0];
            REG_SWING_STARTS:     swing_start_word = data;
            REG_SWING_DURATIONS:  swing_len_word = data;
            REG_STANCE_MODE:      frozen = data[0];
            default: ;
        endcase
        writes_done++;
    endtask

    // Entered and left just after a falling edge; valid stays up unless the next beat idles.
    task automatic send_beat(input logic [15:0] adj, input bit use_known,
                             input gait_result_t known);
        gait_result_t predicted;
        while (!steady_flow && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        freq_adjust <= adj;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        if (frozen)
            frozen_beats++;
        predicted = advance_gait(adj);
        pending_steps.push_back(use_known ? known : predicted);
        busy = 1'b1;
        @(negedge clk);
    endtask

    // Registers may only change once every outstanding step has come back.
    task automatic settle();
        if (busy)
        begin
            in_valid <= 1'b0;
            while (pending_steps.size() != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
            busy = 1'b0;
        end
    endtask

    function automatic logic [15:0] draw16(input int unsigned style, input int unsigned lo,
                                           input int unsigned hi);
        logic [31:0] r;
        r = $urandom;
        if (style == 0)
            r = $urandom_range(hi, lo);
        else if (style == 1)
        begin
            case ($urandom_range(2))
                0:       r = 32'h0000;
                1:       r = 32'h0001;
                default: r = 32'hFFFF;
            endcase
        end
        return r[15:0];
    endfunction

    function automatic logic [15:0] draw_adjust(input int unsigned style);
        logic [31:0] r;
        int unsigned pick;
        pick = $urandom_range(9);
        r    = $urandom;
        if (style == 0 && pick < 8)
            r = $urandom_range(1024) - 512;
        else if (pick == 9)
        begin
            case ($urandom_range(3))
                0:       r = 32'h8000;
                1:       r = 32'h7FFF;
                2:       r = 32'h0000;
                default: r = 32'hFFFF;
            endcase
        end
        return r[15:0];
    endfunction

    function automatic logic [63:0] with_noise(input logic [15:0] v);
        logic [63:0] w;
        w       = {$urandom, $urandom};
        w[15:0] = v;
        return w;
    endfunction

    // Style 0 resembles a walking robot, 1 keeps register values extreme, 2 is anything.
    task automatic apply_random_setting(input int ph, output int unsigned style);
        logic [63:0] word;
        style = $urandom_range(2);
        if ($urandom_range(9) < 7)
            cfg_write(REG_NOMINAL_RATE, with_noise(draw16(style, 64, 1024)));
        if ($urandom_range(9) < 7)
            cfg_write(REG_STEP_TIME, with_noise(draw16(style, 300, 3300)));
        if ($urandom_range(9) < 7)
            cfg_write(REG_STRIDE_PERIOD, with_noise(draw16(style, 64, 1024)));
        if ($urandom_range(9) < 7)
            cfg_write(REG_CLEARANCE_HEIGHT, with_noise(draw16(style, 1000, 20000)));
        if ($urandom_range(9) < 7)
        begin
            for (int leg = 0; leg < OUT_LEGS; leg++)
                word[16 * leg +: 16] = draw16(style, 0, 16'hFFFF);
            cfg_write(REG_SWING_STARTS, word);
        end
        if ($urandom_range(9) < 7)
        begin
            for (int leg = 0; leg < OUT_LEGS; leg++)
                word[16 * leg +: 16] = draw16(style, 16'h2000, 16'hA000);
            cfg_write(REG_SWING_DURATIONS, word);
        end
        if (ph % 4 == 1)
            cfg_write(REG_SPARE, {$urandom, $urandom});
        word    = {$urandom, $urandom};
        word[0] = (ph % 5 == 4);
        cfg_write(REG_STANCE_MODE, word);
    endtask

    always @(negedge clk)
        out_ready <= steady_flow || ($urandom_range(99) >= 36);

    always @(posedge clk)
    begin
        gait_result_t seen;
        gait_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.phase     = phase_out;
            seen.mask      = contact_mask;
            seen.time_left = {time_left_3, time_left_2, time_left_1, time_left_0};
            seen.lift      = {lift_3, lift_2, lift_1, lift_0};
            if (pending_steps.size() == 0)
                report_mismatch("result beat with nothing outstanding, phase_out",
                                seen.phase, '0);
            else
            begin
                want = pending_steps.pop_front();
                check_field("phase_out", seen.phase, want.phase);
                check_field("contact_mask", {12'd0, seen.mask}, {12'd0, want.mask});
                for (int leg = 0; leg < OUT_LEGS; leg++)
                begin
                    check_field($sformatf("time_left_%0d", leg), seen.time_left[leg],
                                want.time_left[leg]);
                    check_field($sformatf("lift_%0d", leg), seen.lift[leg], want.lift[leg]);
                end
            end
            results_seen++;
        end
    end

    initial
    begin
        int unsigned style;
        for (int k = 0; k <= SINE_DEPTH; k++)
            quarter_sine[k] = sine_point(k);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_plan[r])
        begin
            case (opening_plan[r].kind)
                ROW_WRITE:
                begin
                    settle();
                    cfg_write(opening_plan[r].idx, opening_plan[r].data);
                end
                ROW_BEAT:  send_beat(opening_plan[r].adj, 1'b0, '0);
                ROW_KNOWN: send_beat(opening_plan[r].adj, 1'b1, opening_plan[r].known);
                default: ;
            endcase
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            // One phase runs with both sides flowing freely.
            steady_flow = (ph == 6);
            apply_random_setting(ph, style);
            repeat (BEATS_PER_PHASE)
                send_beat(draw_adjust(style), 1'b0, '0);
        end
        settle();

        $display("Control steps driven: %0d, of which %0d with the phase frozen in stance",
                 beats_sent, frozen_beats);
        $display("Result beats checked: %0d over %0d register writes, mismatches: %0d",
                 results_seen, writes_done, mismatches);
        if (mismatches == 0)
            $display("gait_phase_generator verification clean");
        else
            $display("gait_phase_generator verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Watchdog expired with %0d results outstanding", pending_steps.size());
        $display("gait_phase_generator verification failed");
        $finish;
    end

endmodule
